FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the multiplier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/bsm_pkg.sv
// ----------------------------------------------------------------------------
// Booth multiplier package
// Shared widths, payload types and pipeline constants.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned InBits         = 16;
  localparam int unsigned OutBits        = 32;
  localparam int unsigned DefaultWidth   = 16;
  localparam int unsigned RoundsPerStage = 2;

  typedef logic signed [InBits-1:0]  operand_t;
  typedef logic signed [OutBits-1:0] product_t;

endpackage

FILE: rtl/core/bsm_if.sv
// ----------------------------------------------------------------------------
// Booth multiplier channels
// Valid/ready channels for operand beats and product beats.
// ----------------------------------------------------------------------------
interface bsm_in_if;
  import bsm_pkg::*;

  logic     valid;
  logic     ready;
  operand_t multiplicand;
  operand_t multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_out_if;
  import bsm_pkg::*;

  logic     valid;
  logic     ready;
  product_t product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

FILE: rtl/core/booth_signed_multiplier_top.sv
// ----------------------------------------------------------------------------
// Booth signed multiplier
// Pipelined radix-2 Booth multiplier with valid/ready channels.
// ----------------------------------------------------------------------------
// Operand beats arrive on in_i and carry a signed multiplicand and multiplier.
// Each operand is sign-extended and cut to WIDTH bits. Product beats leave on
// out_o and carry the 2*WIDTH-bit register result A:Q, zero-extended or cut
// to 32 bits.
// The Booth rounds are spread over ceil(WIDTH/2) register stages, two rounds
// per stage, and a beat passes through every stage register in order before
// it reaches out_o. One beat enters per cycle while in_i.ready is high.
// The accumulator wraps at WIDTH bits in every round, so a most-negative
// multiplicand gives the classic register result rather than the true product.
// Reset empties every stage; no beat is in flight afterwards.
// When the receiver stalls, the last stage holds its beat and the stages
// behind it keep filling bubbles; in_i.ready drops only when every stage
// holds a beat and out_o is stalled. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module booth_signed_multiplier_top #(
  parameter int unsigned WIDTH = bsm_pkg::DefaultWidth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsm_in_if.sink    in_i,
  bsm_out_if.source out_o
);
  import bsm_pkg::*;

  localparam int unsigned NumStages = (WIDTH + RoundsPerStage - 1) / RoundsPerStage;

  logic             vld [NumStages+1];
  logic             rdy [NumStages+1];
  logic [WIDTH-1:0] a_s [NumStages+1];
  logic [WIDTH-1:0] q_s [NumStages+1];
  logic             q1_s [NumStages+1];
  logic [WIDTH-1:0] m_s [NumStages+1];

  logic [2*InBits-1:0]  mcand_ext;
  logic [2*InBits-1:0]  mplier_ext;
  logic [2*WIDTH-1:0]   prod_full;
  logic [2*OutBits-1:0] prod_ext;
  logic [NumStages-1:0] stage_vld;

  assign mcand_ext  = {{InBits{in_i.multiplicand[InBits-1]}}, in_i.multiplicand};
  assign mplier_ext = {{InBits{in_i.multiplier[InBits-1]}}, in_i.multiplier};

  assign vld[0]  = in_i.valid;
  assign a_s[0]  = '0;
  assign q_s[0]  = mplier_ext[WIDTH-1:0];
  assign q1_s[0] = 1'b0;
  assign m_s[0]  = mcand_ext[WIDTH-1:0];
  assign in_i.ready = rdy[0];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    bsm_stage #(
      .Width      (WIDTH),
      .FirstRound (k * RoundsPerStage)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .a_i     (a_s[k]),
      .q_i     (q_s[k]),
      .q1_i    (q1_s[k]),
      .m_i     (m_s[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .a_o     (a_s[k+1]),
      .q_o     (q_s[k+1]),
      .q1_o    (q1_s[k+1]),
      .m_o     (m_s[k+1])
    );
    assign stage_vld[k] = vld[k+1];
  end

  assign rdy[NumStages] = out_o.ready;
  assign prod_full      = {a_s[NumStages], q_s[NumStages]};
  assign prod_ext       = (2*OutBits)'(prod_full);
  assign out_o.valid    = vld[NumStages];
  assign out_o.product  = prod_ext[OutBits-1:0];

  // The stage count tracks beats taken in minus beats handed out.
  `ASSERT_IMPLY(a_occupancy, clk_i, rst_ni, $past(rst_ni),
    $countones(stage_vld) == $countones($past(stage_vld))
      + int'($past(in_i.valid && in_i.ready)) - int'($past(out_o.valid && out_o.ready)))
  // The input stalls only when every stage is full and the output is blocked.
  `ASSERT_IMPLY(a_full_stall, clk_i, rst_ni, !in_i.ready,
    (&stage_vld) && !out_o.ready)
  // A blocked product beat stays in the last stage unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready,
    out_o.valid && $stable(out_o.product))

endmodule

FILE: rtl/core/bsm_stage.sv
// ----------------------------------------------------------------------------
// Booth pipeline stage
// Runs a fixed slice of Booth rounds on A:Q:Q_1 and registers the result.
// ----------------------------------------------------------------------------
module bsm_stage #(
  parameter int unsigned Width      = bsm_pkg::DefaultWidth,
  parameter int unsigned FirstRound = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] q_i,
  input  logic             q1_i,
  input  logic [Width-1:0] m_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] a_o,
  output logic [Width-1:0] q_o,
  output logic             q1_o,
  output logic [Width-1:0] m_o
);
  import bsm_pkg::*;

  logic             valid_q;
  logic [Width-1:0] a_q, a_d;
  logic [Width-1:0] q_q, q_d;
  logic             q1_q, q1_d;
  logic [Width-1:0] m_q;

  always_comb begin
    logic [Width-1:0] a_t;
    a_t  = a_i;
    a_d  = a_i;
    q_d  = q_i;
    q1_d = q1_i;
    for (int unsigned r = 0; r < RoundsPerStage; r++) begin
      if (FirstRound + r < Width) begin
        a_t = a_d;
        if (q_d[0] && !q1_d) begin
          a_t = a_d - m_i;
        end else if (!q_d[0] && q1_d) begin
          a_t = a_d + m_i;
        end
        q1_d = q_d[0];
        q_d  = {a_t[0], q_d[Width-1:1]};
        a_d  = {a_t[Width-1], a_t[Width-1:1]};
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_q  <= a_d;
      q_q  <= q_d;
      q1_q <= q1_d;
      m_q  <= m_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign q_o     = q_q;
  assign q1_o    = q1_q;
  assign m_o     = m_q;

endmodule
